// ----- hw/rtl/assembly_token_scanner_core_assert.svh -----
// Assertion macros used by the scanner top module.
`ifndef ASSEMBLY_TOKEN_SCANNER_CORE_ASSERT_SVH
`define ASSEMBLY_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define ATSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner assertion failed");

// Next-cycle implication, sampled on clk, disabled in reset.
`define ATSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner assertion failed");

`endif

// ----- hw/rtl/atsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package atsc_pkg;

	localparam int NUM_EXTRA_REGS  = 16;
	localparam int WORD_CHARS_KEPT = 8;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register indexes stay below 1000, so at most three digits can match.
	localparam int REG_DIGITS_MAX = 3;
	localparam int RNUM_W = 10;
	localparam int NUM_NAMED = 35;

	localparam logic [5:0] KIND_COMMA  = 6'd25;
	localparam logic [5:0] KIND_SEMI   = 6'd26;
	localparam logic [5:0] KIND_COLON  = 6'd27;
	localparam logic [5:0] KIND_NUMREG = 6'd35;
	localparam logic [5:0] KIND_WORD   = 6'd36;
	localparam logic [5:0] KIND_NUMBER = 6'd37;
	localparam logic [5:0] KIND_END    = 6'd38;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Names packed first character in the low byte; delimiter slots are empty.
	localparam logic [31:0] KW_TEXT [NUM_NAMED] = '{
		32'h00766f6d, 32'h00646f6c, 32'h00766173, 32'h0069646c, 32'h00646461,
		32'h006e696d, 32'h006c756d, 32'h00766964, 32'h00646f6d, 32'h00687467,
		32'h0068746c, 32'h00716567, 32'h0071656c, 32'h00757165, 32'h0071656e,
		32'h646e616c, 32'h00726f6c, 32'h00746f6e, 32'h646e6162, 32'h00726f62,
		32'h746f6e62, 32'h00726f78, 32'h00706d6a, 32'h007a696a, 32'h007a6e6a,
		32'h00000000, 32'h00000000, 32'h00000000,
		32'h00000061, 32'h00000062, 32'h00000063, 32'h00007069, 32'h00007073,
		32'h00706273, 32'h00676c66
	};

	localparam logic [2:0] KW_LEN [NUM_NAMED] = '{
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3,
		3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd0, 3'd0, 3'd0,
		3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3
	};

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WORD = 3'd1,
		MODE_ZERO = 3'd2,
		MODE_DEC  = 3'd3,
		MODE_HEX  = 3'd4
	} scan_mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [63:0] num;
		logic [63:0] text;
		logic [7:0]  len;
		logic        last;
	} tok_rec_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/assembly_token_scanner_core.sv -----
// Channel  | Handshake            | Word contents
// input    | in_valid / in_ready  | input_char
// output   | out_valid / out_ready| token_kind, number_value, word_text, word_length,
//          |                      | word_truncated, last_of_run
//
// Scanner takes one character per cycle while in_ready is high; a character that closes
// a token and also yields a delimiter or end pushes two tokens, and the token port
// drains one per cycle while out_ready is high. Each token passes through the queue
// and the output register. The four-entry token queue between the scanner and the
// classifier sets backpressure: in_ready drops while fewer than two entries are free.
// arst_n clears scan mode, queue pointers and output valid; no clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

`include "assembly_token_scanner_core_assert.svh"

module assembly_token_scanner_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  input_char,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       token_kind,
	output logic [63:0]      number_value,
	output logic [63:0]      word_text,
	output logic [7:0]       word_length,
	output logic             word_truncated,
	output logic             last_of_run
);

	logic [1:0]                     push_n;
	atsc_pkg::tok_rec_t             push_a, push_b, head;
	logic                           pop, q_empty, q_room;
	logic [atsc_pkg::QCNT_W-1:0]    q_count;

	atsc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.input_char (input_char),
		.q_room     (q_room),
		.push_n     (push_n),
		.push_a     (push_a),
		.push_b     (push_b)
	);

	atsc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push_a (push_a),
		.push_b (push_b),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.room   (q_room),
		.count  (q_count)
	);

	atsc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.token_kind     (token_kind),
		.number_value   (number_value),
		.word_text      (word_text),
		.word_length    (word_length),
		.word_truncated (word_truncated),
		.last_of_run    (last_of_run)
	);

	`ATSC_ASSERT_NOW(a_pop_nonempty, pop, q_count != '0)
	`ATSC_ASSERT_NOW(a_accept_room, in_valid && in_ready,
		q_count <= atsc_pkg::QCNT_W'(atsc_pkg::QDEPTH - 2))
	`ATSC_ASSERT_NOW(a_trunc_word, out_valid && word_truncated,
		(token_kind == atsc_pkg::KIND_WORD) && (word_length > 8'(atsc_pkg::WORD_CHARS_KEPT)))
	`ATSC_ASSERT_NOW(a_end_last, out_valid && (token_kind == atsc_pkg::KIND_END),
		last_of_run && (number_value == '0) && (word_length == '0))
	`ATSC_ASSERT_NEXT(a_double_push, push_n == 2'd2, q_count >= atsc_pkg::QCNT_W'(1))

endmodule

`default_nettype wire

// ----- hw/rtl/atsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module atsc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        input_char,
	input  wire logic              q_room,
	output logic [1:0]             push_n,
	output atsc_pkg::tok_rec_t     push_a,
	output atsc_pkg::tok_rec_t     push_b
);

	atsc_pkg::scan_mode_t mode_q, mode_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] wbuf_q, wbuf_d;
	logic [7:0]  wcnt_q, wcnt_d;

	logic [7:0] lc;
	logic       dig, alp, hexd, wordch, take;
	logic [3:0] hval;
	logic       r0_v, r1_v;
	atsc_pkg::tok_rec_t r0, r1;

	assign in_ready = q_room;
	assign take     = in_valid && q_room;

	always_comb begin
		lc     = ((input_char >= atsc_pkg::CH_UA) && (input_char <= atsc_pkg::CH_UZ)) ?
			input_char + 8'd32 : input_char;
		dig    = atsc_pkg::is_digit(input_char);
		alp    = atsc_pkg::is_alpha(input_char);
		hexd   = dig || ((lc >= atsc_pkg::CH_LA) && (lc <= atsc_pkg::CH_LF));
		wordch = alp || dig || (input_char == atsc_pkg::CH_UNDER);
		hval   = dig ? lc[3:0] : lc[3:0] + 4'd9;
	end

	always_comb begin
		logic closing;
		mode_d = mode_q;
		acc_d  = acc_q;
		wbuf_d = wbuf_q;
		wcnt_d = wcnt_q;
		r0     = '0;
		r1     = '0;
		r0_v   = 1'b0;
		r1_v   = 1'b0;
		closing = 1'b0;

		unique case (mode_q)
			atsc_pkg::MODE_WORD: begin
				if (wordch) begin
					for (int i = 0; i < 8; i++) begin
						if ((wcnt_q == 8'(i)) && (i < atsc_pkg::WORD_CHARS_KEPT)) begin
							wbuf_d[8*i +: 8] = lc;
						end
					end
					if (wcnt_q != 8'hff) begin
						wcnt_d = wcnt_q + 8'd1;
					end
				end else begin
					r0_v    = 1'b1;
					r0.kind = atsc_pkg::KIND_WORD;
					r0.text = wbuf_q;
					r0.len  = wcnt_q;
					closing = 1'b1;
				end
			end
			atsc_pkg::MODE_ZERO, atsc_pkg::MODE_DEC: begin
				if ((mode_q == atsc_pkg::MODE_ZERO) && (lc == atsc_pkg::CH_X)) begin
					mode_d = atsc_pkg::MODE_HEX;
					acc_d  = '0;
				end else if (dig) begin
					acc_d  = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + 64'(lc[3:0]);
					mode_d = atsc_pkg::MODE_DEC;
				end else begin
					r0_v    = 1'b1;
					r0.kind = atsc_pkg::KIND_NUMBER;
					r0.num  = acc_q;
					closing = 1'b1;
				end
			end
			atsc_pkg::MODE_HEX: begin
				if (hexd) begin
					acc_d = {acc_q[59:0], hval};
				end else begin
					r0_v    = 1'b1;
					r0.kind = atsc_pkg::KIND_NUMBER;
					r0.num  = acc_q;
					closing = 1'b1;
				end
			end
			atsc_pkg::MODE_IDLE: begin
				closing = 1'b1;
			end
			default: begin
				closing = 1'b1;
			end
		endcase

		if (closing) begin
			mode_d = atsc_pkg::MODE_IDLE;
			if (dig) begin
				mode_d = (lc == atsc_pkg::CH_ZERO) ? atsc_pkg::MODE_ZERO : atsc_pkg::MODE_DEC;
				acc_d  = 64'(lc[3:0]);
			end else if (alp || (input_char == atsc_pkg::CH_UNDER)) begin
				mode_d = atsc_pkg::MODE_WORD;
				wbuf_d = {56'd0, lc};
				wcnt_d = 8'd1;
			end else if (input_char == atsc_pkg::CH_COMMA) begin
				r1_v    = 1'b1;
				r1.kind = atsc_pkg::KIND_COMMA;
			end else if (input_char == atsc_pkg::CH_SEMI) begin
				r1_v    = 1'b1;
				r1.kind = atsc_pkg::KIND_SEMI;
			end else if (input_char == atsc_pkg::CH_COLON) begin
				r1_v    = 1'b1;
				r1.kind = atsc_pkg::KIND_COLON;
			end else if (input_char == atsc_pkg::CH_NUL) begin
				r1_v    = 1'b1;
				r1.kind = atsc_pkg::KIND_END;
			end
		end

		r0.last = !r1_v;
		r1.last = 1'b1;
	end

	always_comb begin
		push_a = r0_v ? r0 : r1;
		push_b = r1;
		if (!take) begin
			push_n = 2'd0;
		end else begin
			push_n = 2'(r0_v) + 2'(r1_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= atsc_pkg::MODE_IDLE;
		end else if (take) begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_q  <= acc_d;
			wbuf_q <= wbuf_d;
			wcnt_q <= wcnt_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/atsc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module atsc_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [1:0]                   push_n,
	input  wire atsc_pkg::tok_rec_t           push_a,
	input  wire atsc_pkg::tok_rec_t           push_b,
	input  wire logic                         pop,
	output atsc_pkg::tok_rec_t                head,
	output logic                              empty,
	output logic                              room,
	output logic [atsc_pkg::QCNT_W-1:0]       count
);

	atsc_pkg::tok_rec_t entry_q [atsc_pkg::QDEPTH];
	logic [atsc_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [atsc_pkg::QCNT_W-1:0] cnt_q;

	assign head  = entry_q[rd_q];
	assign empty = (cnt_q == '0);
	assign room  = (cnt_q <= atsc_pkg::QCNT_W'(atsc_pkg::QDEPTH - 2));
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + atsc_pkg::QPTR_W'(push_n);
			rd_q  <= rd_q + atsc_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + atsc_pkg::QCNT_W'(push_n) - atsc_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_q] <= push_a;
		end
		if (push_n == 2'd2) begin
			entry_q[wr_q + atsc_pkg::QPTR_W'(1)] <= push_b;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/atsc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module atsc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire atsc_pkg::tok_rec_t   head,
	input  wire logic                 q_empty,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [5:0]                token_kind,
	output logic [63:0]               number_value,
	output logic [63:0]               word_text,
	output logic [7:0]                word_length,
	output logic                      word_truncated,
	output logic                      last_of_run
);

	logic        valid_q;
	logic [5:0]  kind_q, kind_d;
	logic [63:0] num_q, num_d;
	logic [63:0] text_q, text_d;
	logic [7:0]  len_q, len_d;
	logic        trunc_q, trunc_d;
	logic        last_q;

	assign pop = !q_empty && (!valid_q || out_ready);

	always_comb begin
		logic                     kw_hit, nr_ok, in_kept;
		logic [5:0]               kw_kind;
		logic [atsc_pkg::RNUM_W-1:0] v;
		logic [7:0]               ch;

		kw_hit  = 1'b0;
		kw_kind = '0;
		nr_ok   = 1'b0;
		v       = '0;
		in_kept = (head.len >= 8'd1) &&
			(head.len <= 8'(atsc_pkg::WORD_CHARS_KEPT));

		for (int k = 0; k < atsc_pkg::NUM_NAMED; k++) begin
			if ((head.len == 8'(atsc_pkg::KW_LEN[k])) &&
			    (head.text[31:0] == atsc_pkg::KW_TEXT[k]) && (atsc_pkg::KW_LEN[k] != 3'd0)) begin
				kw_hit  = 1'b1;
				kw_kind = 6'(k);
			end
		end

		nr_ok = (head.len >= 8'd2) && (head.len <= 8'(atsc_pkg::REG_DIGITS_MAX + 1)) &&
			(head.text[7:0] == atsc_pkg::CH_R) &&
			!((head.text[15:8] == atsc_pkg::CH_ZERO) && (head.len > 8'd2));
		for (int i = 1; i <= atsc_pkg::REG_DIGITS_MAX; i++) begin
			ch = head.text[8*i +: 8];
			if (head.len > 8'(i)) begin
				if (!atsc_pkg::is_digit(ch)) begin
					nr_ok = 1'b0;
				end
				v = {v[atsc_pkg::RNUM_W-4:0], 3'b000} + {v[atsc_pkg::RNUM_W-2:0], 1'b0} +
					atsc_pkg::RNUM_W'(ch[3:0]);
			end
		end
		nr_ok = nr_ok && (v < atsc_pkg::RNUM_W'(atsc_pkg::NUM_EXTRA_REGS));

		kind_d  = head.kind;
		num_d   = head.num;
		text_d  = head.text;
		len_d   = head.len;
		trunc_d = 1'b0;
		if (head.kind == atsc_pkg::KIND_WORD) begin
			priority if (in_kept && kw_hit) begin
				kind_d = kw_kind;
				text_d = '0;
				len_d  = '0;
			end else if (in_kept && nr_ok) begin
				kind_d = atsc_pkg::KIND_NUMREG;
				num_d  = 64'(v);
				text_d = '0;
				len_d  = '0;
			end else begin
				trunc_d = (head.len > 8'(atsc_pkg::WORD_CHARS_KEPT));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= kind_d;
			num_q   <= num_d;
			text_q  <= text_d;
			len_q   <= len_d;
			trunc_q <= trunc_d;
			last_q  <= head.last;
		end
	end

	assign out_valid      = valid_q;
	assign token_kind     = kind_q;
	assign number_value   = num_q;
	assign word_text      = text_q;
	assign word_length    = len_q;
	assign word_truncated = trunc_q;
	assign last_of_run    = last_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_assembly_token_scanner_core.sv -----
`timescale 1ns / 1ps

module tb_assembly_token_scanner_core;
	import atsc_pkg::*;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CASE_GAP   = CH_LA - CH_UA;
	localparam int         WORD_LEN_MAX = 255;

	typedef struct {
		logic [5:0]  kind;
		logic [63:0] num;
		logic [63:0] text;
		logic [7:0]  len;
		logic        trunc;
		logic        last;
	} scan_token_t;

	// Index is the token kind; delimiter slots stay empty.
	string kw_names [NUM_NAMED] = '{
		"mov", "lod", "sav", "ldi", "add", "min", "mul", "div", "mod", "gth",
		"lth", "geq", "leq", "equ", "neq", "land", "lor", "not", "band", "bor",
		"bnot", "xor", "jmp", "jiz", "jnz", "", "", "",
		"a", "b", "c", "ip", "sp", "sbp", "flg"
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  input_char = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  token_kind;
	logic [63:0] number_value;
	logic [63:0] word_text;
	logic [7:0]  word_length;
	logic        word_truncated;
	logic        last_of_run;

	scan_token_t expected_tokens [$];
	scan_mode_t  scan_state = MODE_IDLE;
	logic [63:0] num_acc = '0;
	logic [63:0] word_buf = '0;
	logic [7:0]  word_cnt = '0;

	int mismatches = 0;
	int chars_sent = 0;
	int rx_hold = 0;
	bit idle_on = 1'b1;

	assembly_token_scanner_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.input_char    (input_char),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_kind    (token_kind),
		.number_value  (number_value),
		.word_text     (word_text),
		.word_length   (word_length),
		.word_truncated(word_truncated),
		.last_of_run   (last_of_run)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic bit char_is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit char_is_letter(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic scan_token_t make_token(input logic [5:0] kind, input logic [63:0] num,
			input logic [63:0] text, input logic [7:0] len, input logic trunc);
		scan_token_t t;
		t.kind = kind;
		t.num = num;
		t.text = text;
		t.len = len;
		t.trunc = trunc;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic void expect_token(input scan_token_t t);
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	function automatic void word_append(input logic [7:0] c);
		if (word_cnt < WORD_CHARS_KEPT)
			word_buf[8 * word_cnt +: 8] = c;
		if (word_cnt < WORD_LEN_MAX)
			word_cnt++;
	endfunction

	function automatic scan_token_t classify_word();
		int n;
		bit hit;
		bit all_digits;
		logic [63:0] v;
		string name;
		n = word_cnt;
		if (n >= 1 && n <= WORD_CHARS_KEPT) begin
			for (int k = 0; k < NUM_NAMED; k++) begin
				name = kw_names[k];
				if (name.len() != n)
					continue;
				hit = 1'b1;
				for (int i = 0; i < n; i++)
					if (word_buf[8 * i +: 8] != name[i])
						hit = 1'b0;
				if (hit)
					return make_token(6'(k), '0, '0, '0, 1'b0);
			end
			if (n >= 2 && word_buf[7:0] == CH_R && !(word_buf[15:8] == CH_ZERO && n > 2)) begin
				v = '0;
				all_digits = 1'b1;
				for (int i = 1; i < n; i++) begin
					if (!char_is_digit(word_buf[8 * i +: 8]))
						all_digits = 1'b0;
					else
						v = v * 64'd10 + 64'(word_buf[8 * i +: 8] - CH_ZERO);
				end
				if (all_digits && v < NUM_EXTRA_REGS)
					return make_token(KIND_NUMREG, v, '0, '0, 1'b0);
			end
		end
		return make_token(KIND_WORD, '0, word_buf, word_cnt, n > WORD_CHARS_KEPT);
	endfunction

	function automatic void predict_char(input logic [7:0] raw);
		logic [7:0] c;
		int first;
		first = expected_tokens.size();
		c = (raw >= CH_UA && raw <= CH_UZ) ? raw + CASE_GAP : raw;
		case (scan_state)
			MODE_WORD: begin
				if (char_is_letter(raw) || char_is_digit(raw) || raw == CH_UNDER) begin
					word_append(c);
					return;
				end
				expect_token(classify_word());
				scan_state = MODE_IDLE;
			end
			MODE_ZERO, MODE_DEC: begin
				if (scan_state == MODE_ZERO && c == CH_X) begin
					scan_state = MODE_HEX;
					num_acc = '0;
					return;
				end
				if (char_is_digit(c)) begin
					num_acc = num_acc * 64'd10 + 64'(c - CH_ZERO);
					scan_state = MODE_DEC;
					return;
				end
				expect_token(make_token(KIND_NUMBER, num_acc, '0, '0, 1'b0));
				scan_state = MODE_IDLE;
			end
			MODE_HEX: begin
				if (char_is_digit(c)) begin
					num_acc = {num_acc[59:0], 4'(c - CH_ZERO)};
					return;
				end
				if (c >= CH_LA && c <= CH_LF) begin
					num_acc = {num_acc[59:0], 4'(c - CH_LA + 8'd10)};
					return;
				end
				expect_token(make_token(KIND_NUMBER, num_acc, '0, '0, 1'b0));
				scan_state = MODE_IDLE;
			end
			default: scan_state = MODE_IDLE;
		endcase

		if (char_is_digit(c)) begin
			scan_state = (c == CH_ZERO) ? MODE_ZERO : MODE_DEC;
			num_acc = 64'(c - CH_ZERO);
		end else if (char_is_letter(raw) || raw == CH_UNDER) begin
			scan_state = MODE_WORD;
			word_buf = '0;
			word_cnt = '0;
			word_append(c);
		end else if (c == CH_COMMA) begin
			expect_token(make_token(KIND_COMMA, '0, '0, '0, 1'b0));
		end else if (c == CH_SEMI) begin
			expect_token(make_token(KIND_SEMI, '0, '0, '0, 1'b0));
		end else if (c == CH_COLON) begin
			expect_token(make_token(KIND_COLON, '0, '0, '0, 1'b0));
		end else if (c == CH_NUL) begin
			expect_token(make_token(KIND_END, '0, '0, '0, 1'b0));
		end

		if (expected_tokens.size() > first)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		scan_token_t t;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: token expected none got kind %0d", $time, token_kind);
				mismatches++;
			end else begin
				t = expected_tokens.pop_front();
				check_field("token_kind", t.kind, token_kind);
				check_field("number_value", t.num, number_value);
				check_field("word_text", t.text, word_text);
				check_field("word_length", t.len, word_length);
				check_field("word_truncated", t.trunc, word_truncated);
				check_field("last_of_run", t.last, last_of_run);
			end
		end
	end

	// Token sink: long hold on request, random stall bursts while idling is on.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_char(input logic [7:0] ch);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		input_char <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_char(ch);
		chars_sent++;
	endtask

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		if (c >= CH_LA && c <= CH_LZ && $urandom_range(0, 1))
			return c - CASE_GAP;
		return c;
	endfunction

	task automatic send_mixed(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(mixed_case(s[i]));
	endtask

	task automatic send_identifier(input int len);
		int pick;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6 || (i == 0 && pick < 9))
				send_char(mixed_case(CH_LA + 8'($urandom_range(0, 25))));
			else if (pick < 9)
				send_char(CH_ZERO + 8'($urandom_range(0, 9)));
			else
				send_char(CH_UNDER);
		end
	endtask

	task automatic send_decimal(input int ndig);
		for (int i = 0; i < ndig; i++)
			send_char(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_hex(input int ndig);
		int d;
		send_char(CH_ZERO);
		send_char(mixed_case(CH_X));
		for (int i = 0; i < ndig; i++) begin
			d = $urandom_range(0, 15);
			if (d < 10)
				send_char(CH_ZERO + 8'(d));
			else
				send_char(mixed_case(CH_LA + 8'(d - 10)));
		end
	endtask

	task automatic send_separator();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			send_char(CH_SPACE);
		else if (pick < 55)
			send_char(CH_COMMA);
		else if (pick < 63)
			send_char(CH_SEMI);
		else if (pick < 70)
			send_char(CH_COLON);
		else if (pick < 80)
			return;
		else if (pick < 85)
			send_char($urandom_range(0, 1) ? CH_TAB : CH_NEWLINE);
		else if (pick < 92)
			send_char(8'($urandom_range(1, 255)));
		else
			send_char(CH_NUL);
	endtask

	task automatic send_random_token();
		int pick;
		int k;
		int idx;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			send_char(8'($urandom_range(0, 255)));
			return;
		end
		if (pick < 30) begin
			do
				k = $urandom_range(0, NUM_NAMED - 1);
			while (kw_names[k].len() == 0);
			send_mixed(kw_names[k]);
		end else if (pick < 40) begin
			idx = $urandom_range(0, 20);
			case ($urandom_range(0, 5))
				0: send_mixed("r");
				1: send_mixed($sformatf("r0%0d", idx));
				default: send_mixed($sformatf("r%0d", idx));
			endcase
		end else if (pick < 55) begin
			send_identifier($urandom_range(1, 12));
		end else if (pick < 70) begin
			send_decimal($urandom_range(1, 24));
		end else if (pick < 82) begin
			send_hex($urandom_range(0, 18));
		end else begin
			case ($urandom_range(0, 2))
				0: send_char(CH_COMMA);
				1: send_char(CH_SEMI);
				default: send_char(CH_COLON);
			endcase
		end
		send_separator();
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		send_mixed("Mov r15,0x;007aB:0Xg");
		send_char(8'h80);
		send_char(8'hff);
		send_char(CH_UNDER);
		send_char(CH_NUL);
		send_char(CH_NUL);
	endtask

	task automatic test_long_words();
		send_identifier(WORD_CHARS_KEPT);
		send_char(CH_SEMI);
		send_identifier(WORD_CHARS_KEPT + 1);
		send_char(CH_COMMA);
		send_identifier(WORD_LEN_MAX + 5);
		send_char(CH_NUL);
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		rx_hold = 300;
		repeat (5) begin
			send_mixed("add r3,");
			send_decimal(3);
			send_char(CH_SEMI);
		end
	endtask

	task automatic test_random(input int budget);
		int start;
		start = chars_sent;
		idle_on = 1'b1;
		while (chars_sent - start < budget) begin
			if ($urandom_range(0, 99) < 3)
				idle_on = !idle_on;
			send_random_token();
		end
	endtask

	task automatic test_quiet_tail(input int budget);
		int start;
		start = chars_sent;
		idle_on = 1'b0;
		while (chars_sent - start < budget)
			send_random_token();
		send_char(CH_NUL);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_words();
		test_backpressure();
		test_random(540);
		test_quiet_tail(150);
		in_valid <= 1'b0;
		for (int i = 0; i < 5000 && expected_tokens.size() != 0; i++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_tokens.size() != 0)
			$display("%0t: %0d tokens expected, none seen", $time, expected_tokens.size());
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
